>>> sv/m3i_pkg.sv
// Package for the 3x3 matrix inverse: widths, payload types and the cofactor table.
// Used by the interfaces and by every module of the block; depends on nothing.
`default_nettype none

package m3i_pkg;

   // Element format: signed fixed point.
   localparam int EW   = 32;           // element width
   localparam int FB   = 16;           // fraction bits
   localparam int NEL  = 9;            // elements per matrix

   // Internal widths, all exact.
   localparam int PW   = 2 * EW;       // element product
   localparam int CW   = PW + 1;       // cofactor
   localparam int PPW  = 2 * EW + 1;   // element times one cofactor half
   localparam int TW   = EW + CW;      // element times full cofactor
   localparam int DETW = TW + 2;       // determinant, sum of three terms
   localparam int DW   = DETW + 1;     // divisor, twice the determinant magnitude
   localparam int RW   = DW + 1;       // partial remainder before compare
   localparam int SH   = 2 * FB + 1;   // numerator alignment shift
   localparam int NW   = ((CW + SH > DETW) ? CW + SH : DETW) + 1;  // numerator
   localparam int QB   = EW + 1;       // quotient bits produced per lane
   localparam int RBW  = NW - QB;      // numerator bits above the quotient bits
   localparam int DP   = QB + 2;       // divisor pipeline taps shared by the lanes
   localparam int LANE_LAT   = QB + 4; // lane latency in cycles
   localparam int PIPE_DEPTH = LANE_LAT + 6;

   typedef logic signed [EW-1:0]   elem_type;
   typedef logic signed [CW-1:0]   cof_type;
   typedef logic signed [DETW-1:0] det_type;
   typedef logic        [DETW-1:0] dabs_type;

   typedef struct packed {
      elem_type a00;
      elem_type a01;
      elem_type a02;
      elem_type a10;
      elem_type a11;
      elem_type a12;
      elem_type a20;
      elem_type a21;
      elem_type a22;
   } req_payload_type;

   typedef struct packed {
      elem_type r00;
      elem_type r01;
      elem_type r02;
      elem_type r10;
      elem_type r11;
      elem_type r12;
      elem_type r20;
      elem_type r21;
      elem_type r22;
      logic     singular;
      logic     overflow;
   } rsp_payload_type;

   // Adjugate entry i is a[P0A]*a[P0B] - a[P1A]*a[P1B], elements row-major.
   localparam int unsigned CF_P0A [NEL] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
   localparam int unsigned CF_P0B [NEL] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
   localparam int unsigned CF_P1A [NEL] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
   localparam int unsigned CF_P1B [NEL] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

endpackage

`default_nettype wire

>>> sv/m3i_if.sv
// Valid/ready channel interfaces for the matrix inverse request and response.
// Depends on m3i_pkg for the payload types.
`default_nettype none

interface m3i_req_if import m3i_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface m3i_rsp_if import m3i_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/m3i_cof.sv
// Cofactor stages: element pair products, then the nine adjugate entries.
// Depends on m3i_pkg.
`default_nettype none

module m3i_cof import m3i_pkg::*; (
   input  wire logic     clock,
   input  wire logic     en,
   input  elem_type      a    [NEL],
   output cof_type       cof  [NEL],
   output elem_type      arow [3]
);

   logic signed [PW-1:0] pa_ff [NEL];
   logic signed [PW-1:0] pb_ff [NEL];
   elem_type             arow1_ff [3];
   cof_type              cof_ff   [NEL];
   elem_type             arow2_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NEL; i++) begin
            pa_ff[i]  <= a[CF_P0A[i]] * a[CF_P0B[i]];
            pb_ff[i]  <= a[CF_P1A[i]] * a[CF_P1B[i]];
            cof_ff[i] <= CW'(pa_ff[i]) - CW'(pb_ff[i]);
         end
         for (int j = 0; j < 3; j++) begin
            arow1_ff[j] <= a[j];
            arow2_ff[j] <= arow1_ff[j];
         end
      end
   end

   assign cof  = cof_ff;
   assign arow = arow2_ff;

endmodule

`default_nettype wire

>>> sv/m3i_det.sv
// Determinant stages: row 0 expansion against the cofactors, split in halves.
// Depends on m3i_pkg.
`default_nettype none

module m3i_det import m3i_pkg::*; (
   input  wire logic     clock,
   input  wire logic     en,
   input  cof_type       cof_i  [NEL],
   input  elem_type      arow   [3],
   output cof_type       cof_o  [NEL],
   output det_type       det
);

   logic signed [PPW-1:0] lo_ff [3];
   logic signed [PPW-1:0] hi_ff [3];
   cof_type               cof3_ff [NEL];
   cof_type               cof4_ff [NEL];
   det_type               det_ff;
   det_type               det_in;

   // Sum of the three element-times-cofactor terms, rebuilt from the halves.
   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + (DETW'(hi_ff[j]) <<< EW) + DETW'(lo_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            lo_ff[j] <= arow[j] * $signed({1'b0, cof_i[3*j][EW-1:0]});
            hi_ff[j] <= arow[j] * $signed(cof_i[3*j][CW-1:EW]);
         end
         for (int i = 0; i < NEL; i++) begin
            cof3_ff[i] <= cof_i[i];
            cof4_ff[i] <= cof3_ff[i];
         end
         det_ff <= det_in;
      end
   end

   assign cof_o = cof4_ff;
   assign det   = det_ff;

endmodule

`default_nettype wire

>>> sv/m3i_lane.sv
// One division lane: cofactor over determinant, rounded, saturated, one quotient
// bit per stage. Depends on m3i_pkg; the divisor taps come from the top level.
`default_nettype none

module m3i_lane import m3i_pkg::*; (
   input  wire logic     clock,
   input  wire logic     en,
   input  cof_type       cof,
   input  wire logic     det_neg,
   input  dabs_type      dabs [DP],
   output elem_type      elem,
   output logic          ovf
);

   localparam logic [QB-1:0] LIM_POS = {2'b00, {(EW-1){1'b1}}};
   localparam logic [QB-1:0] LIM_NEG = {2'b01, {(EW-1){1'b0}}};

   logic [CW-1:0]  cabs_ff;
   logic           nega_ff;
   logic [RBW-1:0] remb_ff;
   logic [QB-1:0]  lowb_ff;
   logic           negb_ff;
   logic [NW-1:0]  num;

   logic [DW-1:0]  rem_ff [QB+1];
   logic [DW-1:0]  rem_in [QB+1];
   logic [QB-1:0]  low_ff [QB+1];
   logic [QB-1:0]  low_in [QB+1];
   logic [QB-1:0]  q_ff   [QB+1];
   logic [QB-1:0]  q_in   [QB+1];
   logic           neg_ff [QB+1];
   logic           big_ff [QB+1];

   logic [RW-1:0]  r2     [QB];
   logic [RW-1:0]  dd     [QB];
   logic           ge     [QB];

   logic [QB-1:0]  lim;
   logic [QB-1:0]  mag;
   logic [QB-1:0]  sgn;
   logic           sat;
   elem_type       elem_ff;
   logic           ovf_ff;

   // Rounded quotient is floor((|cof|*2^(2F+1) + |det|) / (2|det|)).
   assign num = (NW'(cabs_ff) << SH) + NW'(dabs[0]);

   always_comb begin
      rem_in[0] = DW'(remb_ff);
      low_in[0] = lowb_ff;
      q_in[0]   = '0;
      for (int t = 0; t < QB; t++) begin
         r2[t] = {rem_ff[t], low_ff[t][QB-1]};
         dd[t] = {1'b0, dabs[2+t], 1'b0};
         ge[t] = (r2[t] >= dd[t]);
         rem_in[t+1] = ge[t] ? DW'(r2[t] - dd[t]) : DW'(r2[t]);
         low_in[t+1] = low_ff[t] << 1;
         q_in[t+1]   = {q_ff[t][QB-2:0], ge[t]};
      end
   end

   always_comb begin
      lim  = neg_ff[QB] ? LIM_NEG : LIM_POS;
      sat  = big_ff[QB] || (q_ff[QB] > lim);
      mag  = sat ? lim : q_ff[QB];
      sgn  = neg_ff[QB] ? (QB'(0) - mag) : mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cabs_ff <= cof[CW-1] ? CW'(-cof) : CW'(cof);
         nega_ff <= cof[CW-1] ^ det_neg;
         remb_ff <= num[NW-1:QB];
         lowb_ff <= num[QB-1:0];
         negb_ff <= nega_ff;
         // A quotient of 2^QB or more is flagged here and saturates at the end.
         big_ff[0] <= (DW'(remb_ff) >= {dabs[1], 1'b0});
         neg_ff[0] <= negb_ff;
         for (int s = 0; s <= QB; s++) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            q_ff[s]   <= q_in[s];
         end
         for (int s = 1; s <= QB; s++) begin
            big_ff[s] <= big_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
         elem_ff <= sgn[EW-1:0];
         ovf_ff  <= sat;
      end
   end

   assign elem = elem_ff;
   assign ovf  = ovf_ff;

endmodule

`default_nettype wire

>>> sv/matrix3_inverse.sv
// 3x3 matrix inverse by the adjugate, signed fixed point, one matrix per beat.
//
// Channels: req_ch carries one matrix a00..a22 per beat; rsp_ch returns one
// beat per matrix with the inverse r00..r22 and the singular and overflow flags.
// A beat moves on a rising clock edge where valid and ready are both high.
// Path: the cofactor, determinant, stage five and lane stages, then the output register.
// Throughput: one matrix per cycle while rsp_ch is not stalled; the nine division
// lanes are fully pipelined with one quotient bit per stage, so their 33 quotient
// bits set the bulk of the latency but not the rate.
// Each element is rounded to nearest, ties away from zero, and saturates to the
// element range with overflow raised. A zero determinant gives all-zero elements
// with singular raised and overflow low.
// Stall: the whole pipeline holds while the output register is full and
// rsp_ch.ready is low; req_ch.ready is low exactly then.
// Reset: synchronous and active high; it empties the pipeline. The block keeps
// no state between matrices.
// Depends on m3i_pkg, m3i_if, m3i_cof, m3i_det and m3i_lane.
`default_nettype none

module matrix3_inverse import m3i_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   m3i_req_if.sink        req_ch,
   m3i_rsp_if.source      rsp_ch
);

   logic            adv;
   logic            vld_ff [PIPE_DEPTH];
   elem_type        a      [NEL];
   cof_type         cof2   [NEL];
   elem_type        arow2  [3];
   cof_type         cof4   [NEL];
   det_type         det4;

   // Stage five: determinant sign, magnitude and zero test.
   cof_type         cof5_ff [NEL];
   logic            det_neg_ff;
   dabs_type        det_abs_ff;
   logic            det_zero_ff;

   // Divisor magnitude shared by all lanes, one tap per lane stage that uses the divisor.
   dabs_type        dd_ff   [DP];
   logic            sing_ff [LANE_LAT];

   elem_type        lane_elem [NEL];
   logic            lane_ovf  [NEL];
   logic            any_ovf;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   // Everything moves together unless a finished beat is waiting at the output.
   assign adv          = !vld_ff[PIPE_DEPTH-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign rsp_ch.valid = vld_ff[PIPE_DEPTH-1];
   assign rsp_ch.data  = rsp_ff;

   assign a[0] = req_ch.data.a00;
   assign a[1] = req_ch.data.a01;
   assign a[2] = req_ch.data.a02;
   assign a[3] = req_ch.data.a10;
   assign a[4] = req_ch.data.a11;
   assign a[5] = req_ch.data.a12;
   assign a[6] = req_ch.data.a20;
   assign a[7] = req_ch.data.a21;
   assign a[8] = req_ch.data.a22;

   m3i_cof u_cof (
      .clock (clock),
      .en    (adv),
      .a     (a),
      .cof   (cof2),
      .arow  (arow2)
   );

   m3i_det u_det (
      .clock (clock),
      .en    (adv),
      .cof_i (cof2),
      .arow  (arow2),
      .cof_o (cof4),
      .det   (det4)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_DEPTH; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_ch.valid;
         for (int s = 1; s < PIPE_DEPTH; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cof5_ff     <= cof4;
         det_neg_ff  <= det4[DETW-1];
         det_abs_ff  <= det4[DETW-1] ? DETW'(-det4) : DETW'(det4);
         det_zero_ff <= (det4 == '0);
         dd_ff[0]    <= det_abs_ff;
         for (int s = 1; s < DP; s++) begin
            dd_ff[s] <= dd_ff[s-1];
         end
         sing_ff[0] <= det_zero_ff;
         for (int s = 1; s < LANE_LAT; s++) begin
            sing_ff[s] <= sing_ff[s-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   for (genvar g = 0; g < NEL; g++) begin : g_lane
      m3i_lane u_lane (
         .clock   (clock),
         .en      (adv),
         .cof     (cof5_ff[g]),
         .det_neg (det_neg_ff),
         .dabs    (dd_ff),
         .elem    (lane_elem[g]),
         .ovf     (lane_ovf[g])
      );
   end

   // Merge: gather the nine lanes, fold the overflow flags, and clear all
   // elements when the determinant was zero.
   always_comb begin
      any_ovf = 1'b0;
      for (int i = 0; i < NEL; i++) begin
         any_ovf = any_ovf | lane_ovf[i];
      end
      rsp_in.r00 = lane_elem[0];
      rsp_in.r01 = lane_elem[1];
      rsp_in.r02 = lane_elem[2];
      rsp_in.r10 = lane_elem[3];
      rsp_in.r11 = lane_elem[4];
      rsp_in.r12 = lane_elem[5];
      rsp_in.r20 = lane_elem[6];
      rsp_in.r21 = lane_elem[7];
      rsp_in.r22 = lane_elem[8];
      rsp_in.singular = sing_ff[LANE_LAT-1];
      rsp_in.overflow = any_ovf;
      if (sing_ff[LANE_LAT-1]) begin
         rsp_in = '0;
         rsp_in.singular = 1'b1;
      end
   end

endmodule

`default_nettype wire
